[rtl/core/ntpsrb_pkg.sv]
// Shared types, constants and helper functions of the NTP server reply builder.
`timescale 1ns / 1ps

package ntpsrb_pkg;

  localparam int unsigned JobFifoDepth = 2;
  localparam int unsigned ReplyLen     = 48;
  localparam int unsigned OrigFirst    = 40;

  localparam logic [31:0] UnixToNtp = 32'd2208988800;
  // day count of 1970-01-01 in the proleptic count used below
  localparam logic [31:0] EpochDays =
      32'(365 * 1970 + 1969 / 4 - 1969 / 100 + 1969 / 400);

  localparam logic [7:0]  HeaderReset     = 8'd36;
  localparam logic [7:0]  StratumReset    = 8'd4;
  localparam logic [7:0]  PollReset       = 8'd6;
  localparam logic [7:0]  PrecisionReset  = 8'd250;
  localparam logic [31:0] RootDelayReset  = 32'd2048;
  localparam logic [31:0] RootDispReset   = 32'd3072;
  localparam logic [31:0] RefIdReset      = 32'd1196446464;

  typedef enum logic [2:0] {
    REG_HEADER    = 3'd0,
    REG_STRATUM   = 3'd1,
    REG_POLL      = 3'd2,
    REG_PRECISION = 3'd3,
    REG_ROOT_DLY  = 3'd4,
    REG_ROOT_DISP = 3'd5,
    REG_REF_ID    = 3'd6
  } cfg_index_e;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  stratum;
    logic [7:0]  poll_interval;
    logic [7:0]  precision_code;
    logic [31:0] root_delay_word;
    logic [31:0] root_dispersion_word;
    logic [31:0] reference_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0][7:0] orig;
    logic [11:0]     year;
    logic [3:0]      month;
    logic [4:0]      day;
    logic [4:0]      hour;
    logic [5:0]      minute;
    logic [5:0]      second;
  } job_t;

  // days in the year before the first of the month, common year
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/ntpsrb_front.sv]
// Request side: byte position tracking, originate timestamp capture, job issue.
`timescale 1ns / 1ps

module ntpsrb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         request_byte_i,
  input  logic               request_end_i,
  input  logic [11:0]        cal_year_i,
  input  logic [3:0]         cal_month_i,
  input  logic [4:0]         cal_day_i,
  input  logic [4:0]         cal_hour_i,
  input  logic [5:0]         cal_minute_i,
  input  logic [5:0]         cal_second_i,
  input  logic               fifo_full_i,
  output logic               push_o,
  output ntpsrb_pkg::job_t   job_o
);

  logic [5:0]      pos_q, pos_d;
  logic [7:0][7:0] orig_q, orig_d;
  logic            beat;

  assign in_stall_o = fifo_full_i;
  assign beat       = in_valid_i && !fifo_full_i;
  assign push_o     = beat && request_end_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (pos_q == 6'(ntpsrb_pkg::OrigFirst + i)) begin
        orig_d[i] = request_byte_i;
      end else if (pos_q == 6'd0) begin
        orig_d[i] = 8'd0;
      end else begin
        orig_d[i] = orig_q[i];
      end
    end
    if (request_end_i) begin
      pos_d = 6'd0;
    end else if (pos_q < 6'(ntpsrb_pkg::ReplyLen)) begin
      pos_d = pos_q + 6'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    job_o.orig   = orig_d;
    job_o.year   = cal_year_i;
    job_o.month  = cal_month_i;
    job_o.day    = cal_day_i;
    job_o.hour   = cal_hour_i;
    job_o.minute = cal_minute_i;
    job_o.second = cal_second_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 6'd0;
      orig_q <= '0;
    end else if (beat) begin
      pos_q  <= pos_d;
      orig_q <= orig_d;
    end
  end

endmodule

[rtl/core/ntpsrb_job_fifo.sv]
// Small job queue between the request side and the reply side.
`timescale 1ns / 1ps

module ntpsrb_job_fifo #(
  parameter int unsigned Depth = ntpsrb_pkg::JobFifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ntpsrb_pkg::job_t data_i,
  input  logic             pop_i,
  output ntpsrb_pkg::job_t data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ntpsrb_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/ntpsrb_back.sv]
// Reply side: timestamp conversion and serial emission of the 48-byte reply.
`timescale 1ns / 1ps

module ntpsrb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ntpsrb_pkg::cfg_t cfg_i,
  input  logic             empty_i,
  input  ntpsrb_pkg::job_t job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       reply_byte_o,
  output logic             reply_end_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_DAYS,
    ST_SECS
  } calc_state_e;

  typedef enum logic {
    EM_WAIT,
    EM_SEND
  } emit_state_e;

  calc_state_e      state_q;
  emit_state_e      emit_q;
  ntpsrb_pkg::job_t job_q;
  logic [31:0]      year_days_q, days_q, ts_q;
  logic             leap_q;
  logic [16:0]      sod_q;
  logic [5:0]       idx_q;
  logic             out_valid_q, reply_end_q;
  logic [7:0]       reply_byte_q;

  // year stage
  logic [11:0] yr, yr_m1;
  logic [24:0] p_mul, y_mul;
  logic [5:0]  p_div100, y_div100;
  logic [6:0]  y_rem100;
  logic [9:0]  leaps;
  logic        leap_yr;
  logic [31:0] year_days;
  // day stage
  logic [3:0]  mon;
  logic [31:0] days;
  logic [16:0] sod;
  // emission
  logic [31:0] word;
  logic [7:0]  sel_byte;
  logic        slot_free;

  always_comb begin
    yr       = job_q.year;
    yr_m1    = yr - 12'd1;
    p_mul    = 25'(yr_m1) * 25'd5243;
    y_mul    = 25'(yr) * 25'd5243;
    p_div100 = p_mul[24:19];
    y_div100 = y_mul[24:19];
    y_rem100 = 7'(yr - 12'(13'(y_div100) * 13'd100));
    leaps    = (yr == 12'd0) ? 10'd0
             : 10'(yr_m1[11:2]) - 10'(p_div100) + 10'(p_div100[5:2]);
    leap_yr  = ((yr[1:0] == 2'd0) && (y_rem100 != 7'd0))
            || ((y_rem100 == 7'd0) && (y_div100[1:0] == 2'd0));
    year_days = 32'(21'(yr) * 21'd365) + 32'(leaps) - ntpsrb_pkg::EpochDays;
  end

  always_comb begin
    if (job_q.month == 4'd0) begin
      mon = 4'd1;
    end else if (job_q.month > 4'd12) begin
      mon = 4'd12;
    end else begin
      mon = job_q.month;
    end
    days = year_days_q + 32'(ntpsrb_pkg::days_before_month(mon))
         + 32'(leap_q && (mon > 4'd2)) + 32'(job_q.day) - 32'd1;
    sod  = 17'(job_q.hour) * 17'd3600 + 17'(job_q.minute) * 17'd60
         + 17'(job_q.second);
  end

  always_comb begin
    unique case (idx_q[5:2])
      4'd0:    word = {cfg_i.header_byte, cfg_i.stratum, cfg_i.poll_interval,
                       cfg_i.precision_code};
      4'd1:    word = cfg_i.root_delay_word;
      4'd2:    word = cfg_i.root_dispersion_word;
      4'd3:    word = cfg_i.reference_id;
      4'd4:    word = ts_q;
      4'd6:    word = {job_q.orig[0], job_q.orig[1], job_q.orig[2], job_q.orig[3]};
      4'd7:    word = {job_q.orig[4], job_q.orig[5], job_q.orig[6], job_q.orig[7]};
      4'd8:    word = ts_q;
      4'd10:   word = ts_q;
      default: word = 32'd0;
    endcase
    unique case (idx_q[1:0])
      2'd0:    sel_byte = word[31:24];
      2'd1:    sel_byte = word[23:16];
      2'd2:    sel_byte = word[15:8];
      default: sel_byte = word[7:0];
    endcase
  end

  assign slot_free    = !out_valid_q || !out_stall_i;
  assign pop_o        = (state_q == ST_IDLE) && (emit_q == EM_WAIT) && !empty_i;
  assign out_valid_o  = out_valid_q;
  assign reply_byte_o = reply_byte_q;
  assign reply_end_o  = reply_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      emit_q       <= EM_WAIT;
      job_q        <= '0;
      year_days_q  <= '0;
      leap_q       <= 1'b0;
      days_q       <= '0;
      sod_q        <= '0;
      ts_q         <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      reply_byte_q <= '0;
      reply_end_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            job_q   <= job_i;
            state_q <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          year_days_q <= year_days;
          leap_q      <= leap_yr;
          state_q     <= ST_DAYS;
        end
        ST_DAYS: begin
          days_q  <= days;
          sod_q   <= sod;
          state_q <= ST_SECS;
        end
        ST_SECS: begin
          ts_q    <= 32'(days_q * 32'd86400) + 32'(sod_q) + ntpsrb_pkg::UnixToNtp;
          idx_q   <= 6'd0;
          emit_q  <= EM_SEND;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if ((emit_q == EM_SEND) && slot_free) begin
        out_valid_q  <= 1'b1;
        reply_byte_q <= sel_byte;
        reply_end_q  <= (idx_q == 6'(ntpsrb_pkg::ReplyLen - 1));
        idx_q        <= idx_q + 6'd1;
        if (idx_q == 6'(ntpsrb_pkg::ReplyLen - 1)) begin
          emit_q <= EM_WAIT;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/ntp_server_reply_builder_core.sv]
// Top level: NTP server reply builder with configuration registers.
// Request bytes are taken one per cycle; the port stalls only while the job queue is full.
// A final request byte starts a job: queue pop, then time conversion in the year, day and
// seconds states, then the 48 reply bytes one per cycle unless the output stalls.
// The reply side pops the next job only after the last byte of its reply is issued.
// Asynchronous active-low reset clears position, capture bytes, queue; presets registers.
`timescale 1ns / 1ps

module ntp_server_reply_builder_core #(
  parameter int unsigned JobFifoDepth = ntpsrb_pkg::JobFifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  request_byte_i,
  input  logic        request_end_i,
  input  logic [11:0] cal_year_i,
  input  logic [3:0]  cal_month_i,
  input  logic [4:0]  cal_day_i,
  input  logic [4:0]  cal_hour_i,
  input  logic [5:0]  cal_minute_i,
  input  logic [5:0]  cal_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  reply_byte_o,
  output logic        reply_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  ntpsrb_pkg::cfg_t cfg_q;
  ntpsrb_pkg::job_t push_job, head_job;
  logic             fifo_push, fifo_pop, fifo_full, fifo_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_byte          <= ntpsrb_pkg::HeaderReset;
      cfg_q.stratum              <= ntpsrb_pkg::StratumReset;
      cfg_q.poll_interval        <= ntpsrb_pkg::PollReset;
      cfg_q.precision_code       <= ntpsrb_pkg::PrecisionReset;
      cfg_q.root_delay_word      <= ntpsrb_pkg::RootDelayReset;
      cfg_q.root_dispersion_word <= ntpsrb_pkg::RootDispReset;
      cfg_q.reference_id         <= ntpsrb_pkg::RefIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ntpsrb_pkg::REG_HEADER:    cfg_q.header_byte          <= cfg_data_i[7:0];
        ntpsrb_pkg::REG_STRATUM:   cfg_q.stratum              <= cfg_data_i[7:0];
        ntpsrb_pkg::REG_POLL:      cfg_q.poll_interval        <= cfg_data_i[7:0];
        ntpsrb_pkg::REG_PRECISION: cfg_q.precision_code       <= cfg_data_i[7:0];
        ntpsrb_pkg::REG_ROOT_DLY:  cfg_q.root_delay_word      <= cfg_data_i;
        ntpsrb_pkg::REG_ROOT_DISP: cfg_q.root_dispersion_word <= cfg_data_i;
        ntpsrb_pkg::REG_REF_ID:    cfg_q.reference_id         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ntpsrb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .request_byte_i (request_byte_i),
    .request_end_i  (request_end_i),
    .cal_year_i     (cal_year_i),
    .cal_month_i    (cal_month_i),
    .cal_day_i      (cal_day_i),
    .cal_hour_i     (cal_hour_i),
    .cal_minute_i   (cal_minute_i),
    .cal_second_i   (cal_second_i),
    .fifo_full_i    (fifo_full),
    .push_o         (fifo_push),
    .job_o          (push_job)
  );

  ntpsrb_job_fifo #(
    .Depth (JobFifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (push_job),
    .pop_i   (fifo_pop),
    .data_o  (head_job),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  ntpsrb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (fifo_empty),
    .job_i        (head_job),
    .pop_o        (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reply_byte_o (reply_byte_o),
    .reply_end_o  (reply_end_o)
  );

  a_job_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && request_end_i |=> !fifo_empty)
    else $error("final request beat left no job in the queue");

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("job pushed into a full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("job popped from an empty queue");

endmodule
